// File: sv/pepg_pkg.sv
// ----------------------------------------------------------------------------
// pepg_pkg
// Shared types, constants and helpers for the polar ellipse point generator.
// ----------------------------------------------------------------------------
package pepg_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 30;
    localparam int COLOR_BITS     = 24;
    // operand slice width of the shared multiplier
    localparam int CHUNK_BITS     = 24;

    // cos(1/1000) and sin(1/1000) in Q.40
    localparam logic [63:0] COS_Q40 = 64'd1099511078020;
    localparam logic [63:0] SIN_Q40 = 64'd1099511444;

    // input opcodes
    localparam logic OPC_START = 1'b0;
    localparam logic OPC_STEP  = 1'b1;

    // multiply sequence of one rotation step
    typedef enum logic [2:0] {
        MOP_XC  = 3'd0,   // X * cos
        MOP_YAB = 3'd1,   // Y * a/b
        MOP_XBA = 3'd2,   // X * b/a
        MOP_T1S = 3'd3,   // (Y * a/b) * sin
        MOP_YC  = 3'd4,   // Y * cos
        MOP_T2S = 3'd5    // (X * b/a) * sin
    } t_mop;

    typedef struct packed {
        logic       load;
        logic       sel;         // 0: radius a, 1: radius b
        logic       dist_sq;
        logic [1:0] dist_idx;
        logic       dist_first;
        logic       dist_add;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       sqrt_save;
        logic       start_xy;
        logic       div_init;
        logic       div_step;
        logic       div_save;
        logic       mul_init;
        t_mop       mop;
        logic       mul_step;
        logic [3:0] mul_idx;
        logic       mul_acc;
        logic       mul_save;
        logic       upd_xy;
        logic       ofs;
        logic [1:0] emit_idx;
    } t_cmd;

    typedef struct packed {
        logic zero_rad;
        logic done;
        logic div_nz;
    } t_stat;

    // Q.40 constant rounded to Q.frac, tie rounded up
    function automatic logic [63:0] round_q(input logic [63:0] c, input int frac);
        logic [63:0] t;
        t = (c << 1) >> (40 - frac);
        return (t + 64'd1) >> 1;
    endfunction

endpackage

// File: sv/polar_ellipse_point_generator_core.sv
// ----------------------------------------------------------------------------
// polar_ellipse_point_generator_core
// Ellipse pixel generator by incremental polar rotation, fixed point state.
// ----------------------------------------------------------------------------
// Start item: the bit-serial root and ratio divider set the time to first
//   pixel. Step item: six sliced multiplies, each of NP slice products of
//   the 24-bit multiplier (NP = 4 at defaults), come before the first pixel.
// Four pixels follow at one per cycle while i_ready is high; the next item
//   is taken after the fourth.
// Reset (synchronous, active low) returns to idle with no curve running.
module polar_ellipse_point_generator_core
    import pepg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item input
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_opcode,
    input  logic [COORD_BITS-1:0] i_center_x,
    input  logic [COORD_BITS-1:0] i_center_y,
    input  logic [COORD_BITS-1:0] i_x_axis_end_x,
    input  logic [COORD_BITS-1:0] i_x_axis_end_y,
    input  logic [COORD_BITS-1:0] i_y_axis_end_x,
    input  logic [COORD_BITS-1:0] i_y_axis_end_y,
    input  logic [COLOR_BITS-1:0] i_pen_color,
    // pixel output
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COORD_BITS+2:0] o_pixel_x,
    output logic [COORD_BITS+2:0] o_pixel_y,
    output logic [COLOR_BITS-1:0] o_pixel_color,
    output logic                  o_last_of_run,
    output logic                  o_curve_done
);

    t_cmd  cmd;
    t_stat stat;

    // Controller: one-hot sequencer. A start item runs distance and root for
    // each radius and, unless a radius is zero, the ratio divides; a step item
    // runs six sliced multiplies (X*cos, Y*a/b, X*b/a, (Y*a/b)*sin, Y*cos,
    // (X*b/a)*sin), then the saturated update. Both end in four mirrored pixels.
    pepg_ctrl #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_opcode      (i_opcode),
        .o_ready       (o_ready),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_last_of_run (o_last_of_run),
        .o_cmd         (cmd),
        .i_stat        (stat)
    );

    // Datapath: Q.F state X/Y, ratios, shared arithmetic units, and pixel
    // mirror adders driven from the registered integer offsets.
    pepg_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_x_axis_end_x (i_x_axis_end_x),
        .i_x_axis_end_y (i_x_axis_end_y),
        .i_y_axis_end_x (i_y_axis_end_x),
        .i_y_axis_end_y (i_y_axis_end_y),
        .i_pen_color    (i_pen_color),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_color  (o_pixel_color)
    );

    // done flag holds for all four pixels of the finishing item
    assign o_curve_done = stat.done;

endmodule

// File: sv/pepg_dp.sv
// ----------------------------------------------------------------------------
// pepg_dp
// Datapath: radius square root, ratio divider, sliced multiplier, X/Y state.
// ----------------------------------------------------------------------------
module pepg_dp
    import pepg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic [COORD_BITS-1:0]   i_center_x,
    input  logic [COORD_BITS-1:0]   i_center_y,
    input  logic [COORD_BITS-1:0]   i_x_axis_end_x,
    input  logic [COORD_BITS-1:0]   i_x_axis_end_y,
    input  logic [COORD_BITS-1:0]   i_y_axis_end_x,
    input  logic [COORD_BITS-1:0]   i_y_axis_end_y,
    input  logic [COLOR_BITS-1:0]   i_pen_color,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    output logic [COORD_BITS+2:0]   o_pixel_x,
    output logic [COORD_BITS+2:0]   o_pixel_y,
    output logic [COLOR_BITS-1:0]   o_pixel_color
);

    localparam int C   = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int W   = F + 18;
    localparam int RW  = F + C + 2;
    localparam int PW  = C + 3;
    localparam int RTW = C + 1;
    localparam int SW  = 2 * C + 2;
    localparam int NW  = C + 1 + F;
    localparam int CW  = CHUNK_BITS;
    localparam int NA  = (W - 1 + CW - 1) / CW;
    localparam int NK  = (RW + CW - 1) / CW;
    localparam int AW  = CW * (NA + NK);
    localparam int QW  = AW - F;
    localparam logic [W-2:0] LIM_MAG = {(W-1){1'b1}};
    localparam logic [RW-1:0] COS_Q = RW'(round_q(COS_Q40, F));
    localparam logic [RW-1:0] SIN_Q = RW'(round_q(SIN_Q40, F));

    // latched start item
    logic [C-1:0]   r_cx, r_cy, r_ex_x, r_ex_y, r_ey_x, r_ey_y;
    logic [COLOR_BITS-1:0] r_color;

    // distance
    logic [C-1:0]   p_sel, c_sel, d_mag;
    logic [C:0]     d_diff;
    logic [2*C-1:0] r_sqp;
    logic [SW-1:0]  r_dsq;

    // square root
    logic [SW-1:0]  r_sv;
    logic [C+2:0]   r_srem;
    logic [RTW-1:0] r_sroot;
    logic [C+4:0]   sq_t;
    logic [C+4:0]   sq_trial;
    logic           sq_ge;
    logic [RTW-1:0] r_a, r_b;

    // divider
    logic [RTW-1:0] r_drem, r_dd;
    logic [NW-1:0]  r_dq;
    logic [RTW:0]   dv_t;
    logic           dv_ge;
    logic [RW-1:0]  r_rab, r_rba;

    // multiplier
    logic [CW*NA-1:0] r_ma;
    logic [CW*NK-1:0] r_mk;
    logic             r_mneg;
    logic [2*CW-1:0]  r_pp;
    logic [3:0]       r_psh;
    logic [AW-1:0]    r_acc;
    logic [3:0]       mi, mj, pi, pj;
    logic [W-1:0]     m_v, m_vmag;
    logic [RW-1:0]    m_k;
    logic [QW-1:0]    m_q;
    logic [W-2:0]     m_mag;
    logic [W-1:0]     m_res;

    // rotation state
    logic [W-1:0]   r_x, r_y, r_t0, r_t1, r_t2, r_t3, r_t4, r_t5;
    logic [W:0]     sx, sy;
    logic [W-1:0]   xn, yn;
    logic           r_done;
    logic [W-1:0]   x_abs, y_abs, ox_full, oy_full;
    logic [PW-1:0]  r_ox, r_oy, cx_e, cy_e;

    // ---- distance squared, one component a cycle ----
    always_comb begin
        case (i_cmd.dist_idx)
            2'd0:    begin p_sel = r_ex_x; c_sel = r_cx; end
            2'd1:    begin p_sel = r_ex_y; c_sel = r_cy; end
            2'd2:    begin p_sel = r_ey_x; c_sel = r_cx; end
            default: begin p_sel = r_ey_y; c_sel = r_cy; end
        endcase
        d_diff = {1'b0, p_sel} - {1'b0, c_sel};
        d_mag  = d_diff[C] ? C'(-d_diff) : d_diff[C-1:0];
    end

    // ---- square root, one root bit a cycle ----
    always_comb begin
        sq_t     = {r_srem, r_sv[SW-1:SW-2]};
        sq_trial = (C+5)'({r_sroot, 2'b01});
        sq_ge    = sq_t >= sq_trial;
    end

    // ---- restoring divide, one quotient bit a cycle ----
    always_comb begin
        dv_t  = {r_drem, r_dq[NW-1]};
        dv_ge = dv_t >= {1'b0, r_dd};
    end

    // ---- sliced multiplier ----
    always_comb begin
        // slice index decode from a constant table
        mi = '0;
        mj = '0;
        pi = '0;
        pj = '0;
        for (int t = 0; t < NA * NK; t++) begin
            if (i_cmd.mul_idx == 4'(t)) begin
                mi = 4'(t % NA);
                mj = 4'(t / NA);
            end
            if (r_psh == 4'(t)) begin
                pi = 4'(t % NA);
                pj = 4'(t / NA);
            end
        end
        case (i_cmd.mop)
            MOP_XC:  begin m_v = r_x;  m_k = COS_Q; end
            MOP_YAB: begin m_v = r_y;  m_k = r_rab; end
            MOP_XBA: begin m_v = r_x;  m_k = r_rba; end
            MOP_T1S: begin m_v = r_t1; m_k = SIN_Q; end
            MOP_YC:  begin m_v = r_y;  m_k = COS_Q; end
            MOP_T2S: begin m_v = r_t2; m_k = SIN_Q; end
            default: begin m_v = r_x;  m_k = COS_Q; end
        endcase
        m_vmag = m_v[W-1] ? -m_v : m_v;
        m_q    = r_acc[AW-1:F];
        m_mag  = (m_q > QW'(LIM_MAG)) ? LIM_MAG : m_q[W-2:0];
        m_res  = r_mneg ? -{1'b0, m_mag} : {1'b0, m_mag};
    end

    // ---- step update with saturation ----
    always_comb begin
        sx = {r_t0[W-1], r_t0} - {r_t3[W-1], r_t3};
        sy = {r_t4[W-1], r_t4} + {r_t5[W-1], r_t5};
        if ($signed(sx) > $signed({2'b00, LIM_MAG}))       xn = {1'b0, LIM_MAG};
        else if ($signed(sx) < -$signed({2'b00, LIM_MAG})) xn = -{1'b0, LIM_MAG};
        else                                               xn = sx[W-1:0];
        if ($signed(sy) > $signed({2'b00, LIM_MAG}))       yn = {1'b0, LIM_MAG};
        else if ($signed(sy) < -$signed({2'b00, LIM_MAG})) yn = -{1'b0, LIM_MAG};
        else                                               yn = sy[W-1:0];
    end

    // ---- integer offsets, truncated toward zero ----
    always_comb begin
        x_abs   = r_x[W-1] ? -r_x : r_x;
        y_abs   = r_y[W-1] ? -r_y : r_y;
        ox_full = r_x[W-1] ? -(x_abs >> F) : (x_abs >> F);
        oy_full = r_y[W-1] ? -(y_abs >> F) : (y_abs >> F);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx    <= i_center_x;
            r_cy    <= i_center_y;
            r_ex_x  <= i_x_axis_end_x;
            r_ex_y  <= i_x_axis_end_y;
            r_ey_x  <= i_y_axis_end_x;
            r_ey_y  <= i_y_axis_end_y;
            r_color <= i_pen_color;
        end
        if (i_cmd.dist_sq)    r_sqp <= d_mag * d_mag;
        if (i_cmd.dist_first) r_dsq <= SW'(r_sqp);
        if (i_cmd.dist_add)   r_dsq <= r_dsq + SW'(r_sqp);

        if (i_cmd.sqrt_init) begin
            r_sv    <= r_dsq;
            r_srem  <= '0;
            r_sroot <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sv <= {r_sv[SW-3:0], 2'b00};
            if (sq_ge) begin
                r_srem  <= (C+3)'(sq_t - sq_trial);
                r_sroot <= {r_sroot[RTW-2:0], 1'b1};
            end else begin
                r_srem  <= sq_t[C+2:0];
                r_sroot <= {r_sroot[RTW-2:0], 1'b0};
            end
        end
        if (i_cmd.sqrt_save) begin
            if (i_cmd.sel) r_b <= r_sroot;
            else           r_a <= r_sroot;
        end

        if (i_cmd.div_init) begin
            r_drem <= '0;
            r_dq   <= i_cmd.sel ? {r_b, {F{1'b0}}} : {r_a, {F{1'b0}}};
            r_dd   <= i_cmd.sel ? r_a : r_b;
        end else if (i_cmd.div_step) begin
            r_drem <= dv_ge ? RTW'(dv_t - {1'b0, r_dd}) : dv_t[RTW-1:0];
            r_dq   <= {r_dq[NW-2:0], dv_ge};
        end
        if (i_cmd.div_save) begin
            if (i_cmd.sel) r_rba <= RW'(r_dq);
            else           r_rab <= RW'(r_dq);
        end

        if (i_cmd.mul_init) begin
            r_ma   <= (CW*NA)'(m_vmag[W-2:0]);
            r_mk   <= (CW*NK)'(m_k);
            r_mneg <= m_v[W-1];
            r_acc  <= '0;
        end else begin
            if (i_cmd.mul_step) begin
                r_pp  <= r_ma[mi*CW +: CW] * r_mk[mj*CW +: CW];
                r_psh <= i_cmd.mul_idx;
            end
            if (i_cmd.mul_acc) r_acc <= r_acc + (AW'(r_pp) << (CW * (pi + pj)));
        end
        if (i_cmd.mul_save) begin
            case (i_cmd.mop)
                MOP_XC:  r_t0 <= m_res;
                MOP_YAB: r_t1 <= m_res;
                MOP_XBA: r_t2 <= m_res;
                MOP_T1S: r_t3 <= m_res;
                MOP_YC:  r_t4 <= m_res;
                MOP_T2S: r_t5 <= m_res;
                default: r_t0 <= m_res;
            endcase
        end

        if (i_cmd.start_xy) begin
            r_x    <= W'({r_a, {F{1'b0}}});
            r_y    <= '0;
            r_done <= (r_a == '0) || (r_b == '0);
        end else if (i_cmd.upd_xy) begin
            r_x    <= xn;
            r_y    <= yn;
            r_done <= xn[W-1] || (xn == '0);
        end
        if (i_cmd.ofs) begin
            r_ox <= ox_full[PW-1:0];
            r_oy <= oy_full[PW-1:0];
        end
    end

    assign cx_e = PW'(r_cx);
    assign cy_e = PW'(r_cy);
    assign o_pixel_x     = i_cmd.emit_idx[0] ? cx_e - r_ox : cx_e + r_ox;
    assign o_pixel_y     = i_cmd.emit_idx[1] ? cy_e - r_oy : cy_e + r_oy;
    assign o_pixel_color = r_color;

    assign o_stat.zero_rad = (r_a == '0) || (r_b == '0);
    assign o_stat.done     = r_done;
    assign o_stat.div_nz   = (r_dd != '0);

endmodule

// File: sv/pepg_ctrl.sv
// ----------------------------------------------------------------------------
// pepg_ctrl
// Sequencer: walks the datapath through start and step items.
// ----------------------------------------------------------------------------
module pepg_ctrl
    import pepg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_opcode,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    output logic  o_last_of_run,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    localparam int C    = COORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int W    = F + 18;
    localparam int RW   = F + C + 2;
    localparam int NW   = C + 1 + F;
    localparam int NA   = (W - 1 + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int NK   = (RW + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int NP   = NA * NK;
    localparam int CNTW = $clog2(NW + 3);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DIST  = 10'b0000000010,
        S_SQRT  = 10'b0000000100,
        S_INIT  = 10'b0000001000,
        S_DIV   = 10'b0000010000,
        S_MINIT = 10'b0000100000,
        S_MUL   = 10'b0001000000,
        S_UPD   = 10'b0010000000,
        S_OFS   = 10'b0100000000,
        S_EMIT  = 10'b1000000000
    } t_state;

    t_state          r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_sel, n_sel;
    logic            r_active, n_active;
    t_mop            r_op, n_op;
    logic            accept;

    assign accept = i_valid && o_ready;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_sel    = r_sel;
        n_active = r_active;
        n_op     = r_op;
        o_cmd    = '0;
        o_cmd.sel      = r_sel;
        o_cmd.mop      = r_op;
        o_cmd.emit_idx = r_cnt[1:0];
        o_cmd.mul_idx  = 4'(r_cnt);
        o_ready  = (r_state == S_IDLE);
        o_valid  = (r_state == S_EMIT);
        o_last_of_run = (r_state == S_EMIT) && (r_cnt[1:0] == 2'd3);
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    if (i_opcode == OPC_START) begin
                        o_cmd.load = 1'b1;
                        n_sel   = 1'b0;
                        n_state = S_DIST;
                    end else if (r_active) begin
                        n_op    = MOP_XC;
                        n_state = S_MINIT;
                    end
                end
            end
            S_DIST: begin
                o_cmd.dist_sq    = (r_cnt != CNTW'(2));
                o_cmd.dist_idx   = {r_sel, (r_cnt != '0)};
                o_cmd.dist_first = (r_cnt == CNTW'(1));
                o_cmd.dist_add   = (r_cnt == CNTW'(2));
                if (r_cnt == CNTW'(2)) begin
                    n_cnt   = '0;
                    n_state = S_SQRT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_init = (r_cnt == '0);
                o_cmd.sqrt_step = (r_cnt != '0) && (r_cnt <= CNTW'(C + 1));
                o_cmd.sqrt_save = (r_cnt == CNTW'(C + 2));
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNTW'(C + 2)) begin
                    n_cnt = '0;
                    if (r_sel) begin
                        n_state = S_INIT;
                    end else begin
                        n_sel   = 1'b1;
                        n_state = S_DIST;
                    end
                end
            end
            S_INIT: begin
                o_cmd.start_xy = 1'b1;
                n_sel = 1'b0;
                if (i_stat.zero_rad) begin
                    n_active = 1'b0;
                    n_state  = S_OFS;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_init = (r_cnt == '0);
                o_cmd.div_step = (r_cnt != '0) && (r_cnt <= CNTW'(NW));
                o_cmd.div_save = (r_cnt == CNTW'(NW + 1));
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNTW'(NW + 1)) begin
                    n_cnt = '0;
                    if (r_sel) begin
                        n_active = 1'b1;
                        n_state  = S_OFS;
                    end else begin
                        n_sel = 1'b1;
                    end
                end
            end
            S_MINIT: begin
                o_cmd.mul_init = 1'b1;
                n_cnt   = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                // slice products issue in counts 0..NP-1, each accumulated at the next count
                o_cmd.mul_step = (r_cnt < CNTW'(NP));
                o_cmd.mul_acc  = (r_cnt != '0) && (r_cnt <= CNTW'(NP));
                o_cmd.mul_save = (r_cnt == CNTW'(NP + 1));
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNTW'(NP + 1)) begin
                    n_cnt = '0;
                    case (r_op)
                        MOP_XC:  begin n_op = MOP_YAB; n_state = S_MINIT; end
                        MOP_YAB: begin n_op = MOP_XBA; n_state = S_MINIT; end
                        MOP_XBA: begin n_op = MOP_T1S; n_state = S_MINIT; end
                        MOP_T1S: begin n_op = MOP_YC;  n_state = S_MINIT; end
                        MOP_YC:  begin n_op = MOP_T2S; n_state = S_MINIT; end
                        default: n_state = S_UPD;
                    endcase
                end
            end
            S_UPD: begin
                o_cmd.upd_xy = 1'b1;
                n_state = S_OFS;
            end
            S_OFS: begin
                o_cmd.ofs = 1'b1;
                if (i_stat.done) n_active = 1'b0;
                n_cnt   = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_ready) begin
                    if (r_cnt[1:0] == 2'd3) begin
                        n_cnt   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_sel    <= 1'b0;
            r_active <= 1'b0;
            r_op     <= MOP_XC;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_sel    <= n_sel;
            r_active <= n_active;
            r_op     <= n_op;
        end
    end

    // never accept while pixels are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("input ready while output valid");

    // a step with no running curve produces nothing
    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_opcode == OPC_STEP) && !r_active) |=> (r_state == S_IDLE))
        else $error("idle step did not drop");

    // ratio division only with a nonzero divisor
    a_div_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && (r_cnt != '0)) |-> i_stat.div_nz)
        else $error("division by zero radius");

    // the fourth pixel ends the run
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_of_run) |=> !o_valid)
        else $error("pixels after last of run");

endmodule

// File: tb/sv/polar_ellipse_point_generator_core_test.sv
// ----------------------------------------------------------------------------
// polar_ellipse_point_generator_core_test
// Drives start and step items into the ellipse generator, predicts every
// pixel with an independent fixed point model and checks each accepted pixel.
// ----------------------------------------------------------------------------
module polar_ellipse_point_generator_core_test;
    import pepg_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int PB = CB + 3;

    // one predicted or observed pixel
    typedef struct packed {
        logic [PB-1:0]         px;
        logic [PB-1:0]         py;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
        logic                  done;
    } t_pixel;

    // pixel predictor and store of pending pixels
    class pixel_board;
        t_pixel            pending[$];
        int                errors;
        logic [CB-1:0]     ccol, crow;
        logic signed [63:0] xq, yq;
        logic [63:0]       r_ab, r_ba;
        logic [23:0]       color;
        bit                running;
        logic [63:0]       cosq, sinq, lim;

        function new();
            errors = 0; ccol = 0; crow = 0; xq = 0; yq = 0;
            r_ab = 0; r_ba = 0; color = 0; running = 0;
            cosq = ((((COS_Q40 << 1) >> (40 - FB)) + 64'd1) >> 1);
            sinq = ((((SIN_Q40 << 1) >> (40 - FB)) + 64'd1) >> 1);
            lim = (64'd1 << (FB + 17)) - 1;
        endfunction

        // exact product, truncated toward zero, saturated
        function logic signed [63:0] qmul(logic signed [63:0] v, logic [63:0] k);
            logic [63:0]  mag;
            logic [127:0] p;
            logic [127:0] r;
            logic signed [63:0] s;
            mag = v[63] ? -v : v;
            p = {64'd0, mag} * {64'd0, k};
            r = p >> FB;
            s = (r > {64'd0, lim}) ? lim : r[63:0];
            return v[63] ? -s : s;
        endfunction

        function logic signed [63:0] sat(logic signed [63:0] v);
            if (v > $signed(lim)) return lim;
            if (v < -$signed(lim)) return -$signed(lim);
            return v;
        endfunction

        function logic [63:0] root(logic [63:0] v);
            logic [63:0] r;
            r = 0;
            for (int b = 31; b >= 0; b--)
                if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r |= 64'd1 << b;
            return r;
        endfunction

        function logic signed [63:0] ipart(logic signed [63:0] v);
            return v[63] ? -((-v) >>> FB) : (v >>> FB);
        endfunction

        function void push4(bit done);
            logic signed [63:0] x, y;
            t_pixel p;
            x = ipart(xq); y = ipart(yq);
            for (int k = 0; k < 4; k++) begin
                p.px = (k % 2 == 0) ? PB'($signed({1'b0, ccol}) + x)
                                    : PB'($signed({1'b0, ccol}) - x);
                p.py = (k < 2) ? PB'($signed({1'b0, crow}) + y)
                               : PB'($signed({1'b0, crow}) - y);
                p.color = color; p.last = (k == 3); p.done = done;
                pending.push_back(p);
            end
        endfunction

        // note one accepted input item
        function void note_item(logic op, logic [CB-1:0] cx, logic [CB-1:0] cy,
                                logic [CB-1:0] ax, logic [CB-1:0] ay,
                                logic [CB-1:0] bx, logic [CB-1:0] by, logic [23:0] col);
            logic signed [63:0] dx, dy, xn, yn;
            logic [63:0] a, b;
            bit done;
            if (op == OPC_START) begin
                dx = $signed({1'b0, ax}) - $signed({1'b0, cx});
                dy = $signed({1'b0, ay}) - $signed({1'b0, cy});
                a = root(dx * dx + dy * dy);
                dx = $signed({1'b0, bx}) - $signed({1'b0, cx});
                dy = $signed({1'b0, by}) - $signed({1'b0, cy});
                b = root(dx * dx + dy * dy);
                done = (a == 0) || (b == 0);
                ccol = cx; crow = cy; color = col;
                xq = a << FB; yq = 0;
                r_ab = done ? 0 : (a << FB) / b;
                r_ba = done ? 0 : (b << FB) / a;
                running = !done;
                push4(done);
            end else if (running) begin
                xn = sat(qmul(xq, cosq) - qmul(qmul(yq, r_ab), sinq));
                yn = sat(qmul(yq, cosq) + qmul(qmul(xq, r_ba), sinq));
                xq = xn; yq = yn;
                done = (xn <= 0);
                if (done) running = 0;
                push4(done);
            end
        endfunction

        // compare one accepted pixel against the oldest prediction
        function void check_pixel(t_pixel got);
            t_pixel want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected pixel %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) $display("pixel mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, i_ready = 0, o_ready, o_valid;
    logic i_opcode = 0;
    logic [CB-1:0] i_center_x = 0, i_center_y = 0, i_x_axis_end_x = 0, i_x_axis_end_y = 0;
    logic [CB-1:0] i_y_axis_end_x = 0, i_y_axis_end_y = 0;
    logic [23:0] i_pen_color = 0;
    logic [PB-1:0] o_pixel_x, o_pixel_y;
    logic [23:0] o_pixel_color;
    logic o_last_of_run, o_curve_done;

    polar_ellipse_point_generator_core i_dut (.*);

    pixel_board board = new();
    int  cycles = 0;
    bit  calm = 0;      // no idling on either side while set

    initial forever #4 i_clk = ~i_clk;

    // pixel sink with random stalls; results sampled at the edge
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready)
            board.check_pixel({o_pixel_x, o_pixel_y, o_pixel_color,
                               o_last_of_run, o_curve_done});
        i_ready <= calm || ($urandom_range(99) >= 9);
        if (cycles > 400000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // present one item and hold it until accepted
    task automatic send(logic op, logic [CB-1:0] cx, logic [CB-1:0] cy,
                        logic [CB-1:0] ax, logic [CB-1:0] ay,
                        logic [CB-1:0] bx, logic [CB-1:0] by, logic [23:0] col);
        while (!calm && $urandom_range(99) < 9) @(posedge i_clk);
        i_valid <= 1; i_opcode <= op; i_center_x <= cx; i_center_y <= cy;
        i_x_axis_end_x <= ax; i_x_axis_end_y <= ay;
        i_y_axis_end_x <= bx; i_y_axis_end_y <= by; i_pen_color <= col;
        do @(posedge i_clk); while (!o_ready);
        board.note_item(op, cx, cy, ax, ay, bx, by, col);
        i_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic steps(int n);
        for (int k = 0; k < n; k++)
            send(OPC_STEP, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
                 CB'($urandom), CB'($urandom), 24'($urandom));
    endtask

    // random ellipse with small radii about a random centre
    task automatic small_start();
        logic [CB-1:0] cx, cy;
        cx = CB'($urandom); cy = CB'($urandom);
        send(OPC_START, cx, cy, CB'(cx + $urandom_range(6) - 3),
             CB'(cy + $urandom_range(2) - 1), CB'(cx + $urandom_range(2) - 1),
             CB'(cy + $urandom_range(6) - 3), 24'($urandom));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: idle step, zero radius, extremes, restart while running
        send(OPC_STEP, '1, '1, '1, '1, '1, '1, '1);
        send(OPC_START, 100, 100, 100, 100, 105, 100, 24'hABCDEF);
        send(OPC_START, 0, 0, 4095, 4095, 4095, 4095, 24'hFFFFFF);
        steps(3);
        send(OPC_START, 4095, 4095, 0, 0, 4095, 0, 24'h000000);
        steps(2);
        send(OPC_START, 2048, 2048, 2051, 2048, 2048, 2049, 24'h5A5A5A);
        steps(8);
        send(OPC_START, 4095, 0, 4095, 0, 4095, 0, 24'h123456);
        steps(1);
        // random: mostly small-radius starts, some long-radius noise, each followed by up to five steps
        for (int r = 0; r < 40; r++) begin
            calm = (r >= 15 && r < 22);
            if ($urandom_range(3) == 0)
                send(OPC_START, CB'($urandom), CB'($urandom), CB'($urandom),
                     CB'($urandom), CB'($urandom), CB'($urandom), 24'($urandom));
            else small_start();
            steps($urandom_range(5));
        end
        calm = 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
